### design/psb_pkg.sv
// Shared constants, codes and controller/datapath types for the prediction scoreboard.
package psb_pkg;

  localparam int ENTRIES    = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int OP_W       = 2;
  localparam int ID_W       = 16;
  localparam int TICK_W     = 32;
  localparam int DELTA_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ID_W-1:0]            NO_EDGE       = '1;
  localparam logic signed [DELTA_W-1:0]  CONFIRM_RESET = 16'sd64;
  localparam logic signed [DELTA_W-1:0]  MISS_RESET    = -16'sd64;

  typedef enum logic [OP_W-1:0] {
    OP_PREDICT = 2'd0,
    OP_ACTUAL  = 2'd1,
    OP_EXPIRE  = 2'd2,
    OP_CLEAR   = 2'd3
  } psb_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREDICT_EN = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_CONFIRM    = 2'd2,
    REG_MISS       = 2'd3
  } psb_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic append;    // predict item at the port
    logic clear;     // clear item at the port
    logic start;     // latch item, rewind scan
    logic step_act;  // one entry of an actual scan
    logic step_exp;  // one entry of an expire scan
    logic act_emit;  // send actual result
    logic flush;     // send held expire result as last
  } psb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic no_edge;
    logic win_zero;
    logic done;
    logic stall;
    logic found;
    logic stage_valid;
    logic out_free;
  } psb_sts_t;

endpackage

### design/psb_if.sv
// Item channel interfaces: input items and result items.
interface psb_in_if;
  import psb_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ID_W-1:0]     edge_id;
  logic [ID_W-1:0]     target_node;
  logic [ID_W-1:0]     active_query;
  logic [ID_W-1:0]     path_tag;
  logic [TICK_W-1:0]   now_tick;

  modport source (output valid, op, edge_id, target_node, active_query, path_tag, now_tick,
                  input ready);
  modport sink   (input valid, op, edge_id, target_node, active_query, path_tag, now_tick,
                  output ready);
endinterface

interface psb_out_if;
  import psb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ID_W-1:0]            delta_edge;
  logic signed [DELTA_W-1:0]  weight_delta;
  logic                       outcome;
  logic [ID_W-1:0]            delta_tag;
  logic                       last;

  modport source (output valid, delta_edge, weight_delta, outcome, delta_tag, last,
                  input ready);
  modport sink   (input valid, delta_edge, weight_delta, outcome, delta_tag, last,
                  output ready);
endinterface

### design/psb_dp.sv
// Scoreboard datapath: entry table, pending bits, config registers, scan and result registers.
module psb_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [psb_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [psb_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic [psb_pkg::ID_W-1:0]               edge_id_i,
  input  logic [psb_pkg::ID_W-1:0]               target_node_i,
  input  logic [psb_pkg::ID_W-1:0]               active_query_i,
  input  logic [psb_pkg::ID_W-1:0]               path_tag_i,
  input  logic [psb_pkg::TICK_W-1:0]             now_tick_i,
  input  psb_pkg::psb_cmd_t                      cmd_i,
  output psb_pkg::psb_sts_t                      sts_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [psb_pkg::ID_W-1:0]               delta_edge_o,
  output logic signed [psb_pkg::DELTA_W-1:0]     weight_delta_o,
  output logic                                   outcome_o,
  output logic [psb_pkg::ID_W-1:0]               delta_tag_o,
  output logic                                   last_o
);
  import psb_pkg::*;

  // config
  logic                       pred_en_q;
  logic [TICK_W-1:0]          window_q;
  logic signed [DELTA_W-1:0]  confirm_q;
  logic signed [DELTA_W-1:0]  miss_q;

  // table
  logic [TICK_W-1:0]  tick_mem   [ENTRIES];
  logic [ID_W-1:0]    edge_mem   [ENTRIES];
  logic [ID_W-1:0]    target_mem [ENTRIES];
  logic [ID_W-1:0]    query_mem  [ENTRIES];
  logic [ID_W-1:0]    tag_mem    [ENTRIES];
  logic [ENTRIES-1:0] pending_q;
  logic [CNT_W-1:0]   count_q;

  // latched item
  logic [ID_W-1:0]    edge_q, target_q, query_q;
  logic [TICK_W-1:0]  now_q;

  // scan
  logic [CNT_W-1:0]   idx_q;
  logic               fq_valid_q, fa_valid_q;
  logic [IDX_W-1:0]   fq_idx_q, fa_idx_q;

  // held expire result
  logic               stage_valid_q;
  logic [ID_W-1:0]    stage_edge_q, stage_tag_q;

  // result register
  logic                       out_valid_q;
  logic [ID_W-1:0]            out_edge_q, out_tag_q;
  logic signed [DELTA_W-1:0]  out_delta_q;
  logic                       out_outcome_q, out_last_q;

  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   pick_idx;
  logic [TICK_W-1:0]  age;
  logic               exp_hit;
  logic               q_match;
  logic               act_match;
  logic               room;
  logic               out_free;

  assign scan_idx  = idx_q[IDX_W-1:0];
  assign wr_idx    = count_q[IDX_W-1:0];
  assign pick_idx  = fq_valid_q ? fq_idx_q : fa_idx_q;
  assign age       = now_q - tick_mem[scan_idx];
  assign exp_hit   = pending_q[scan_idx] && (age > window_q);
  assign q_match   = (query_q == '0) || (query_mem[scan_idx] == query_q);
  assign act_match = (edge_mem[pick_idx] == edge_q) && (target_mem[pick_idx] == target_q);
  assign room      = count_q < CNT_W'(ENTRIES);
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.no_edge     = (edge_id_i == NO_EDGE);
  assign sts_o.win_zero    = (window_q == '0);
  assign sts_o.done        = (idx_q == count_q);
  assign sts_o.stall       = exp_hit && stage_valid_q && !out_free;
  assign sts_o.found       = fq_valid_q || fa_valid_q;
  assign sts_o.stage_valid = stage_valid_q;
  assign sts_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_en_q <= 1'b0;
      window_q  <= '0;
      confirm_q <= CONFIRM_RESET;
      miss_q    <= MISS_RESET;
    end else if (cfg_we_i) begin
      unique case (psb_reg_e'(cfg_idx_i))
        REG_PREDICT_EN: pred_en_q <= cfg_data_i[0];
        REG_WINDOW:     window_q  <= cfg_data_i[TICK_W-1:0];
        REG_CONFIRM:    confirm_q <= cfg_data_i[DELTA_W-1:0];
        REG_MISS:       miss_q    <= cfg_data_i[DELTA_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && pred_en_q && room) begin
      tick_mem[wr_idx]   <= now_tick_i;
      edge_mem[wr_idx]   <= edge_id_i;
      target_mem[wr_idx] <= target_node_i;
      query_mem[wr_idx]  <= active_query_i;
      tag_mem[wr_idx]    <= path_tag_i;
    end
    if (cmd_i.start) begin
      edge_q   <= edge_id_i;
      target_q <= target_node_i;
      query_q  <= active_query_i;
      now_q    <= now_tick_i;
    end
    if (cmd_i.step_act && pending_q[scan_idx]) begin
      if (!fa_valid_q) fa_idx_q <= scan_idx;
      if (!fq_valid_q && q_match) fq_idx_q <= scan_idx;
    end
    if (cmd_i.step_exp && exp_hit) begin
      stage_edge_q <= edge_mem[scan_idx];
      stage_tag_q  <= tag_mem[scan_idx];
    end
    if (cmd_i.act_emit) begin
      out_edge_q    <= edge_mem[pick_idx];
      out_tag_q     <= tag_mem[pick_idx];
      out_delta_q   <= act_match ? confirm_q : miss_q;
      out_outcome_q <= !act_match;
      out_last_q    <= 1'b1;
    end else if ((cmd_i.step_exp && exp_hit && stage_valid_q) || cmd_i.flush) begin
      out_edge_q    <= stage_edge_q;
      out_tag_q     <= stage_tag_q;
      out_delta_q   <= miss_q;
      out_outcome_q <= 1'b1;
      out_last_q    <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      fq_valid_q    <= 1'b0;
      fa_valid_q    <= 1'b0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.append && pred_en_q && room) begin
        pending_q[wr_idx] <= 1'b1;
        count_q           <= count_q + CNT_W'(1);
      end
      if (cmd_i.clear) count_q <= '0;
      if (cmd_i.start) begin
        idx_q      <= '0;
        fq_valid_q <= 1'b0;
        fa_valid_q <= 1'b0;
      end
      if (cmd_i.step_act) begin
        idx_q <= idx_q + CNT_W'(1);
        if (pending_q[scan_idx]) begin
          fa_valid_q <= 1'b1;
          if (q_match) fq_valid_q <= 1'b1;
        end
      end
      if (cmd_i.step_exp) begin
        idx_q <= idx_q + CNT_W'(1);
        if (exp_hit) begin
          pending_q[scan_idx] <= 1'b0;
          stage_valid_q       <= 1'b1;
        end
      end
      if (cmd_i.act_emit) pending_q[pick_idx] <= 1'b0;
      if (cmd_i.flush) stage_valid_q <= 1'b0;
      if (cmd_i.act_emit || cmd_i.flush || (cmd_i.step_exp && exp_hit && stage_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign delta_edge_o   = out_edge_q;
  assign weight_delta_o = out_delta_q;
  assign outcome_o      = out_outcome_q;
  assign delta_tag_o    = out_tag_q;
  assign last_o         = out_last_q;

endmodule

### design/psb_ctrl.sv
// Scoreboard controller: item acceptance and scan sequencing.
module psb_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [psb_pkg::OP_W-1:0]    in_op_i,
  output logic                        in_ready_o,
  input  psb_pkg::psb_sts_t           sts_i,
  output psb_pkg::psb_cmd_t           cmd_o
);
  import psb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_ACT,
    ST_SCAN_EXP,
    ST_ACT_EMIT,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (psb_op_e'(in_op_i))
            OP_PREDICT: cmd_o.append = 1'b1;
            OP_CLEAR:   cmd_o.clear  = 1'b1;
            OP_ACTUAL: begin
              if (!sts_i.no_edge) begin
                cmd_o.start = 1'b1;
                state_d     = ST_SCAN_ACT;
              end
            end
            OP_EXPIRE: begin
              if (!sts_i.win_zero) begin
                cmd_o.start = 1'b1;
                state_d     = ST_SCAN_EXP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_ACT: begin
        if (sts_i.done) state_d = ST_ACT_EMIT;
        else cmd_o.step_act = 1'b1;
      end
      ST_SCAN_EXP: begin
        if (sts_i.done) state_d = ST_FLUSH;
        else if (!sts_i.stall) cmd_o.step_exp = 1'b1;
      end
      ST_ACT_EMIT: begin
        if (!sts_i.found) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.act_emit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.stage_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/prediction_expectation_scoreboard.sv
// Top level of the prediction expectation scoreboard.
// Holds up to ENTRIES (32) pending edge predictions. Predict and clear items give no
// result. Actual and expire items walk the table one entry per cycle over the filled
// entries; an expire scan pauses on an expired entry while the held result cannot move on.
// An actual item gives at most one result; an expire item gives one result per
// expired entry in table order, the final one flagged by last. The next item is taken
// once the previous one has finished its scan and passed its last result, if any, to
// the result register, which lets a finished result wait while the next item starts.
module prediction_expectation_scoreboard (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  psb_in_if.sink                             in_i,
  psb_out_if.source                          out_o
);
  import psb_pkg::*;

  psb_cmd_t cmd;
  psb_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  psb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .edge_id_i      (in_i.edge_id),
    .target_node_i  (in_i.target_node),
    .active_query_i (in_i.active_query),
    .path_tag_i     (in_i.path_tag),
    .now_tick_i     (in_i.now_tick),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .delta_edge_o   (out_o.delta_edge),
    .weight_delta_o (out_o.weight_delta),
    .outcome_o      (out_o.outcome),
    .delta_tag_o    (out_o.delta_tag),
    .last_o         (out_o.last)
  );

endmodule
